// File: design/assert_macros.svh
// Assertion macros for the RTL of the haplotype bit packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent property checked on the rising clock edge, disabled in reset.
`define HBP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hbp assertion failed");
// Condition that must never hold outside reset.
`define HBP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hbp forbidden condition seen");
`else
`define HBP_ASSERT(label, clk, rst_n, prop)
`define HBP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: design/hbp_pkg.sv
// Package with constants, payload types and helpers of the haplotype bit packer.
`default_nettype none
package hbp_pkg;

  localparam int MAX_HAPS       = 32;
  localparam int ROWS_PER_BLOCK = 32;
  localparam int HAP_LIMIT      = (MAX_HAPS < 32) ? MAX_HAPS : 32;
  localparam int WORD_W         = 32;
  localparam int SLOT_W         = 5;
  localparam int HAP_W          = 5;
  localparam int NH_W           = 6;
  localparam int CNT_W          = 6;
  localparam int BLK_W          = 16;
  localparam int FRAC_BITS      = 16;
  localparam int FREQ_W         = FRAC_BITS + 1;
  localparam int DIV_STEPS      = FRAC_BITS + 1;
  localparam int DIV_CNT_W      = 5;
  localparam int BYTE_COUNT     = WORD_W / 8;
  localparam int BYTE_IDX_W     = 2;

  localparam logic [NH_W-1:0]   NUM_HAPS_RESET = NH_W'(32);
  localparam logic [SLOT_W-1:0] LAST_SLOT      = SLOT_W'(ROWS_PER_BLOCK - 1);

  localparam logic KIND_SITE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DIVIDE,
    ST_SITE,
    ST_FLUSH
  } hbp_state_e;

  typedef struct packed {
    logic [WORD_W-1:0] allele_bits;
    logic              final_site;
  } hbp_in_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] site_slot;
    logic [BLK_W-1:0]  block_index;
    logic [CNT_W-1:0]  allele_count;
    logic [FREQ_W-1:0] frequency_q16;
    logic [HAP_W-1:0]  hap_index;
    logic [WORD_W-1:0] packed_word;
    logic              last;
    logic              final_done;
  } hbp_out_t;

  // Effective haplotype count: zero acts as one, large values saturate.
  function automatic logic [NH_W-1:0] haps_in_use(input logic [NH_W-1:0] raw);
    logic [NH_W-1:0] n;
    n = raw;
    if (n == '0) n = NH_W'(1);
    if (n > NH_W'(HAP_LIMIT)) n = NH_W'(HAP_LIMIT);
    return n;
  endfunction

  // Ones in one byte of a row.
  function automatic logic [3:0] byte_ones(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) c = c + 4'(b[i]);
    return c;
  endfunction

endpackage
`default_nettype wire

// File: design/haplotype_bit_packer_top.sv
// Top level of the haplotype bit packer: corner-turn buffer, counter and divider.
//
// Usage: each input transaction on in_* carries one variant site as a row of
// allele bits (bit h belongs to haplotype h) and a final_site flag. The block
// answers with one site transaction on out_* carrying the alternate-allele
// count among the haplotypes in use and its frequency, count over haplotypes
// in use, in Q1.16 rounded down. When a block of 32 sites is full, or the
// site is marked final, the site transaction is followed by one packed-word
// transaction per haplotype in use, haplotype 0 first, with site slot r at
// bit r; the buffer is then cleared and the block index advances.
// Timing: after an input is accepted the row is counted a byte per cycle,
// then one shared compare-and-subtract unit runs a restoring division of
// 17 steps, one quotient bit per cycle, and the site result is registered.
// in_ready_o returns once the site result, or on a flush the last packed
// word, is in the output register.
// The output register holds a result until out_ready_i takes it; a stalled
// receiver stops the sequencer at the next result, nothing is dropped.
// Reset (rst_ni low) empties the buffer, zeroes the slot and block counters,
// drops out_valid_o and sets num_haps back to 32. The user writes num_haps
// via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"
module haplotype_bit_packer_top
  import hbp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [NH_W-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire hbp_in_t         in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output hbp_out_t             out_o
);

  hbp_state_e state_q, state_d;

  logic [NH_W-1:0]       num_haps_q;
  logic [NH_W-1:0]       n_q;
  logic [NH_W-1:0]       n_eff;
  logic [WORD_W-1:0]     bits_masked;
  logic [WORD_W-1:0]     bits_q;
  logic                  fin_q;
  logic                  flush_q;
  logic [SLOT_W-1:0]     row_ptr_q;
  logic [BLK_W-1:0]      blk_q;
  logic [BYTE_IDX_W-1:0] byte_idx_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic [NH_W-1:0]       rem_q;
  logic [FREQ_W-1:0]     quot_q;
  logic [HAP_W-1:0]      hap_q;
  logic [WORD_W-1:0]     hap_word_q [HAP_LIMIT];

  logic                  out_valid_q;
  hbp_out_t              out_q;

  logic accept, out_free;
  logic count_en, div_en, load_site, load_word;
  logic count_done, div_done, last_word;

  // Shared divider step signals.
  logic [NH_W:0]   trial;
  logic [NH_W:0]   diff;
  logic            ge;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign n_eff    = haps_in_use(num_haps_q);

  always_comb begin
    for (int h = 0; h < WORD_W; h++) begin
      bits_masked[h] = in_i.allele_bits[h] && (NH_W'(h) < n_eff);
    end
  end

  assign count_done = (byte_idx_q == BYTE_IDX_W'(BYTE_COUNT - 1));
  assign div_done   = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign last_word  = ((NH_W'(hap_q) + NH_W'(1)) == n_q);

  // One restoring step: the first step compares the count itself, later ones
  // the doubled remainder, which brings in one zero fraction bit each time.
  assign trial = (div_cnt_q == '0) ? {1'b0, cnt_q} : {rem_q, 1'b0};
  assign diff  = trial - {1'b0, n_q};
  assign ge    = (trial >= {1'b0, n_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_COUNT;
      ST_COUNT:  if (count_done) state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_d = ST_SITE;
      ST_SITE: begin
        if (out_free) state_d = flush_q ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH:  if (out_free && last_word) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    count_en   = 1'b0;
    div_en     = 1'b0;
    load_site  = 1'b0;
    load_word  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_COUNT:  count_en = 1'b1;
      ST_DIVIDE: div_en = 1'b1;
      ST_SITE:   load_site = out_free;
      ST_FLUSH:  load_word = out_free;
      default:   in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      num_haps_q <= NUM_HAPS_RESET;
      row_ptr_q  <= '0;
      blk_q      <= '0;
      byte_idx_q <= '0;
      div_cnt_q  <= '0;
      hap_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) num_haps_q <= cfg_wdata_i;
      if (accept) byte_idx_q <= '0;
      else if (count_en) byte_idx_q <= byte_idx_q + BYTE_IDX_W'(1);
      if (accept) div_cnt_q <= '0;
      else if (div_en) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      if (load_site) begin
        hap_q <= '0;
        if (!flush_q) row_ptr_q <= row_ptr_q + SLOT_W'(1);
      end
      if (load_word) begin
        hap_q <= hap_q + HAP_W'(1);
        if (last_word) begin
          row_ptr_q <= '0;
          blk_q     <= blk_q + BLK_W'(1);
        end
      end
    end
  end

  // Transposed buffer: one word per haplotype, the row lands at its slot bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < HAP_LIMIT; h++) hap_word_q[h] <= '0;
    end else if (load_word && last_word) begin
      for (int h = 0; h < HAP_LIMIT; h++) hap_word_q[h] <= '0;
    end else if (accept) begin
      for (int h = 0; h < HAP_LIMIT; h++) hap_word_q[h][row_ptr_q] <= bits_masked[h];
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bits_q  <= bits_masked;
      fin_q   <= in_i.final_site;
      flush_q <= in_i.final_site || (row_ptr_q == LAST_SLOT);
      n_q     <= n_eff;
      cnt_q   <= '0;
    end else if (count_en) begin
      cnt_q <= cnt_q + CNT_W'(byte_ones(bits_q[byte_idx_q*8 +: 8]));
    end
    if (div_en) begin
      rem_q  <= ge ? diff[NH_W-1:0] : trial[NH_W-1:0];
      quot_q <= {quot_q[FREQ_W-2:0], ge};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_site || load_word) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_site) begin
      out_q.kind          <= KIND_SITE;
      out_q.site_slot     <= row_ptr_q;
      out_q.block_index   <= blk_q;
      out_q.allele_count  <= cnt_q;
      out_q.frequency_q16 <= quot_q;
      out_q.hap_index     <= '0;
      out_q.packed_word   <= '0;
      out_q.last          <= !flush_q;
      out_q.final_done    <= fin_q;
    end else if (load_word) begin
      out_q.kind          <= KIND_WORD;
      out_q.site_slot     <= '0;
      out_q.block_index   <= blk_q;
      out_q.allele_count  <= '0;
      out_q.frequency_q16 <= '0;
      out_q.hap_index     <= hap_q;
      out_q.packed_word   <= hap_word_q[hap_q];
      out_q.last          <= last_word;
      out_q.final_done    <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `HBP_ASSERT(a_div_steps_bounded, clk_i, rst_ni,
    (state_q == ST_DIVIDE) |-> (div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1)))
  `HBP_ASSERT(a_busy_after_accept, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> !in_ready_o)
  `HBP_ASSERT(a_flush_hap_in_range, clk_i, rst_ni,
    (state_q == ST_FLUSH) |-> (NH_W'(hap_q) < n_q))
  `HBP_ASSERT(a_slot_zero_after_flush, clk_i, rst_ni,
    (load_word && last_word) |=> (row_ptr_q == '0))

endmodule
`default_nettype wire
